// File: src/ffba_pkg.sv
`default_nettype none
package ffba_pkg;

  localparam int unsigned DEF_MAX_BLOCKS  = 64;
  localparam int unsigned DEF_OFFSET_BITS = 32;
  localparam int unsigned BYTES_W         = 33;
  localparam int unsigned FRAG_SCALE      = 100;
  localparam logic [31:0] POOL_RESET      = 32'd1048576;
  localparam logic [6:0]  THRESH_RESET    = 7'd50;

  typedef enum logic [2:0] {
    KIND_ALLOC  = 3'd0,
    KIND_FREE   = 3'd1,
    KIND_DEFRAG = 3'd2,
    KIND_CLEAR  = 3'd3,
    KIND_LOOKUP = 3'd4,
    KIND_RSTAT  = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_NO_SPACE = 3'd1,
    STAT_UNKNOWN  = 3'd2,
    STAT_ZERO     = 3'd3,
    STAT_FULL     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CFG_POOL_SIZE = 2'd0,
    CFG_AUTO      = 2'd1,
    CFG_THRESH    = 2'd2
  } cfg_e;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DECODE, S_SCAN_RD, S_SCAN_CHK, S_ALLOC, S_SH_RD, S_SH_WR,
    S_FREE, S_DIV_START, S_DIV_RUN, S_FRAG_CHK, S_DONE, S_MRG_START, S_MRG_LD,
    S_MRG_RD, S_MRG_CHK, S_CLR_RD, S_CLR_WR
  } ffba_state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_INIT, OP_LOAD, OP_DECODE, OP_NOFIT, OP_RETRY, OP_SCAN_RD,
    OP_SCAN_HIT, OP_SCAN_NEXT, OP_FULL, OP_SPLIT, OP_TAKE, OP_SH_RD, OP_SH_WR,
    OP_FREE, OP_DIV_START, OP_DIV_STEP, OP_CHK_CLR, OP_OUT, OP_MRG_START,
    OP_MRG_LD, OP_MRG_RD, OP_MRG_CHK, OP_MRG_END, OP_CLR_RD, OP_CLR_WR, OP_CLR_END
  } dp_op_e;

  typedef struct packed {
    kind_e kind;
    logic  req_zero;
    logic  auto_on;
    logic  retry;
    logic  idx_end;
    logic  match;
    logic  split;
    logic  full;
    logic  div_done;
    logic  chk;
    logic  frag_over;
    logic  out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

// File: src/ffba_ram.sv
`default_nettype none
module ffba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// File: src/ffba_ctrl.sv
`default_nettype none
module ffba_ctrl
  import ffba_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire logic    cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire dp_sts_t sts_i,
  output dp_op_e       op_o
);

  ffba_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    case (state_q)
      S_INIT: begin
        op_o    = OP_INIT;
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_o    = OP_LOAD;
          state_d = S_DECODE;
        end else if (cfg_we_i && cfg_idx_i == CFG_POOL_SIZE) begin
          state_d = S_INIT;
        end
      end
      S_DECODE: begin
        op_o = OP_DECODE;
        case (sts_i.kind)
          KIND_ALLOC:  state_d = sts_i.req_zero ? S_DIV_START : S_SCAN_RD;
          KIND_FREE:   state_d = S_SCAN_RD;
          KIND_LOOKUP: state_d = S_SCAN_RD;
          KIND_DEFRAG: state_d = S_MRG_START;
          KIND_CLEAR:  state_d = S_CLR_RD;
          default:     state_d = S_DIV_START;
        endcase
      end
      S_SCAN_RD: begin
        if (sts_i.idx_end) begin
          if (sts_i.kind == KIND_ALLOC && sts_i.auto_on && !sts_i.retry) begin
            op_o    = OP_RETRY;
            state_d = S_MRG_START;
          end else begin
            op_o    = OP_NOFIT;
            state_d = S_DIV_START;
          end
        end else begin
          op_o    = OP_SCAN_RD;
          state_d = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (sts_i.match) begin
          op_o = OP_SCAN_HIT;
          case (sts_i.kind)
            KIND_ALLOC: state_d = S_ALLOC;
            KIND_FREE:  state_d = S_FREE;
            default:    state_d = S_DIV_START;
          endcase
        end else begin
          op_o    = OP_SCAN_NEXT;
          state_d = S_SCAN_RD;
        end
      end
      S_ALLOC: begin
        if (sts_i.split && sts_i.full) begin
          op_o    = OP_FULL;
          state_d = S_DIV_START;
        end else if (sts_i.split) begin
          op_o    = OP_SPLIT;
          state_d = S_SH_RD;
        end else begin
          op_o    = OP_TAKE;
          state_d = S_DIV_START;
        end
      end
      S_SH_RD: begin
        op_o    = OP_SH_RD;
        state_d = S_SH_WR;
      end
      S_SH_WR: begin
        op_o    = OP_SH_WR;
        state_d = sts_i.idx_end ? S_DIV_START : S_SH_RD;
      end
      S_FREE: begin
        op_o    = OP_FREE;
        state_d = S_DIV_START;
      end
      S_DIV_START: begin
        op_o    = OP_DIV_START;
        state_d = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        if (sts_i.div_done) begin
          state_d = S_FRAG_CHK;
        end else begin
          op_o = OP_DIV_STEP;
        end
      end
      S_FRAG_CHK: begin
        if (sts_i.chk && sts_i.frag_over) begin
          op_o    = OP_CHK_CLR;
          state_d = S_MRG_START;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          op_o    = OP_OUT;
          state_d = S_IDLE;
        end
      end
      S_MRG_START: begin
        op_o    = OP_MRG_START;
        state_d = S_MRG_LD;
      end
      S_MRG_LD: begin
        op_o    = OP_MRG_LD;
        state_d = S_MRG_RD;
      end
      S_MRG_RD: begin
        if (sts_i.idx_end) begin
          op_o    = OP_MRG_END;
          state_d = (sts_i.kind == KIND_ALLOC) ? S_SCAN_RD : S_DIV_START;
        end else begin
          op_o    = OP_MRG_RD;
          state_d = S_MRG_CHK;
        end
      end
      S_MRG_CHK: begin
        op_o    = OP_MRG_CHK;
        state_d = S_MRG_RD;
      end
      S_CLR_RD: begin
        if (sts_i.idx_end) begin
          op_o    = OP_CLR_END;
          state_d = S_MRG_START;
        end else begin
          op_o    = OP_CLR_RD;
          state_d = S_CLR_WR;
        end
      end
      S_CLR_WR: begin
        op_o    = OP_CLR_WR;
        state_d = S_CLR_RD;
      end
      default: state_d = S_INIT;
    endcase
  end

endmodule
`default_nettype wire

// File: src/ffba_dp.sv
`default_nettype none
module ffba_dp
  import ffba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS  = DEF_MAX_BLOCKS,
  parameter int unsigned OFFSET_BITS = DEF_OFFSET_BITS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire dp_op_e                 op_i,
  output dp_sts_t                     sts_o,
  input  wire logic                   cfg_we_i,
  input  wire logic [1:0]             cfg_idx_i,
  input  wire logic [31:0]            cfg_data_i,
  input  wire logic [2:0]             kind_i,
  input  wire logic [31:0]            req_size_i,
  input  wire logic [4:0]             align_log2_i,
  input  wire logic [OFFSET_BITS-1:0] block_offset_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [2:0]                  status_o,
  output logic [OFFSET_BITS-1:0]      result_offset_o,
  output logic [31:0]                 block_bytes_o,
  output logic [31:0]                 bytes_in_use_o,
  output logic [31:0]                 peak_bytes_o,
  output logic [31:0]                 alloc_count_o,
  output logic [31:0]                 free_count_o,
  output logic [6:0]                  frag_pct_o
);

  localparam int unsigned AW  = $clog2(MAX_BLOCKS);
  localparam int unsigned CW  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned NW  = $clog2(MAX_BLOCKS * FRAG_SCALE + 1);
  localparam int unsigned DCW = $clog2(NW + 1);
  localparam int unsigned EW  = 1 + BYTES_W + OFFSET_BITS;

  typedef struct packed {
    logic                   busy;
    logic [BYTES_W-1:0]     bytes;
    logic [OFFSET_BITS-1:0] off;
  } ent_t;

  kind_e                  kind_q;
  status_e                status_q;
  logic                   req_zero_q, retry_q, chk_q, auto_q;
  logic [BYTES_W-1:0]     need_q, amask_q;
  logic [OFFSET_BITS-1:0] boff_q, roff_q;
  logic [31:0]            rbytes_q, usage_q, peak_q, allocs_q, frees_q, pool_q;
  logic [6:0]             thr_q;
  logic [CW-1:0]          idx_q, wptr_q, k_q, cnt_q, nfree_q, rem_q;
  ent_t                   cur_q, hold_q;
  logic [NW-1:0]          num_q, quo_q;
  logic [DCW-1:0]         dcnt_q;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  ent_t                   ram_wdata, rd;
  logic [BYTES_W-1:0]     amask_n, need_n;
  logic [OFFSET_BITS-1:0] cur_end;
  logic                   fit, busy_hit, mrg_ok;
  logic [CW:0]            rem_sh;
  logic [31:0]            usage_add;

  ffba_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rd)
  );

  assign amask_n   = (BYTES_W'(1) << align_log2_i) - BYTES_W'(1);
  assign need_n    = (BYTES_W'(req_size_i) + amask_n) & ~amask_n;
  assign cur_end   = cur_q.off + OFFSET_BITS'(cur_q.bytes);
  assign fit       = !rd.busy && (rd.bytes >= need_q) &&
                     ((rd.off & OFFSET_BITS'(amask_q)) == '0);
  assign busy_hit  = rd.busy && (rd.off == boff_q);
  assign mrg_ok    = !cur_q.busy && !rd.busy && (cur_end == rd.off);
  assign rem_sh    = {rem_q, num_q[NW-1]};
  assign usage_add = usage_q + need_q[31:0];

  always_comb begin
    sts_o.kind      = kind_q;
    sts_o.req_zero  = req_zero_q;
    sts_o.auto_on   = auto_q;
    sts_o.retry     = retry_q;
    sts_o.idx_end   = (idx_q == cnt_q);
    sts_o.match     = (kind_q == KIND_ALLOC) ? fit : busy_hit;
    sts_o.split     = (cur_q.bytes > need_q);
    sts_o.full      = (cnt_q >= CW'(MAX_BLOCKS));
    sts_o.div_done  = (dcnt_q == '0);
    sts_o.chk       = chk_q;
    sts_o.frag_over = (7'(quo_q) > thr_q);
    sts_o.out_free  = !out_valid_o || !out_stall_i;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q[AW-1:0];
    ram_wdata = cur_q;
    ram_raddr = idx_q[AW-1:0];
    case (op_i)
      OP_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = '{busy: 1'b0, bytes: BYTES_W'(pool_q), off: '0};
      end
      OP_SPLIT: begin
        ram_we    = 1'b1;
        ram_waddr = k_q[AW-1:0];
        ram_wdata = '{busy: 1'b1, bytes: need_q, off: cur_q.off};
      end
      OP_TAKE: begin
        ram_we    = 1'b1;
        ram_waddr = k_q[AW-1:0];
        ram_wdata = '{busy: 1'b1, bytes: cur_q.bytes, off: cur_q.off};
      end
      OP_FREE: begin
        ram_we    = 1'b1;
        ram_waddr = k_q[AW-1:0];
        ram_wdata = '{busy: 1'b0, bytes: cur_q.bytes, off: cur_q.off};
      end
      OP_SH_WR: begin
        ram_we    = 1'b1;
        ram_wdata = hold_q;
      end
      OP_MRG_START: ram_raddr = '0;
      OP_MRG_CHK: begin
        ram_we    = !mrg_ok;
        ram_waddr = wptr_q[AW-1:0];
      end
      OP_MRG_END: begin
        ram_we    = 1'b1;
        ram_waddr = wptr_q[AW-1:0];
      end
      OP_CLR_WR: begin
        ram_we    = 1'b1;
        ram_wdata = '{busy: 1'b0, bytes: rd.bytes, off: rd.off};
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_ALLOC;
      status_q <= STAT_OK;
      req_zero_q <= 1'b0;
      retry_q <= 1'b0;
      chk_q <= 1'b0;
      auto_q <= 1'b1;
      thr_q <= THRESH_RESET;
      pool_q <= POOL_RESET;
      need_q <= '0;
      amask_q <= '0;
      boff_q <= '0;
      roff_q <= '0;
      rbytes_q <= '0;
      usage_q <= '0;
      peak_q <= '0;
      allocs_q <= '0;
      frees_q <= '0;
      idx_q <= '0;
      wptr_q <= '0;
      k_q <= '0;
      cnt_q <= CW'(1);
      nfree_q <= CW'(1);
      rem_q <= '0;
      cur_q <= '0;
      hold_q <= '0;
      num_q <= '0;
      quo_q <= '0;
      dcnt_q <= '0;
      out_valid_o <= 1'b0;
      status_o <= '0;
      result_offset_o <= '0;
      block_bytes_o <= '0;
      bytes_in_use_o <= '0;
      peak_bytes_o <= '0;
      alloc_count_o <= '0;
      free_count_o <= '0;
      frag_pct_o <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_POOL_SIZE: pool_q <= cfg_data_i;
          CFG_AUTO:      auto_q <= cfg_data_i[0];
          CFG_THRESH:    thr_q <= cfg_data_i[6:0];
          default:       pool_q <= pool_q;
        endcase
      end
      if (op_i == OP_OUT) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      case (op_i)
        OP_INIT: begin
          cnt_q   <= CW'(1);
          nfree_q <= CW'(1);
          usage_q <= '0;
        end
        OP_LOAD: begin
          kind_q     <= kind_e'(kind_i);
          req_zero_q <= (req_size_i == '0);
          amask_q    <= amask_n;
          need_q     <= need_n;
          boff_q     <= block_offset_i;
          status_q   <= (kind_i == KIND_ALLOC && req_size_i == '0) ? STAT_ZERO : STAT_OK;
          roff_q     <= '0;
          rbytes_q   <= '0;
          retry_q    <= 1'b0;
          chk_q      <= 1'b0;
          idx_q      <= '0;
        end
        OP_DECODE: begin
          if (kind_q == KIND_CLEAR) begin
            usage_q <= '0;
            frees_q <= frees_q + allocs_q;
          end else if (kind_q == KIND_RSTAT) begin
            peak_q   <= usage_q;
            allocs_q <= '0;
            frees_q  <= '0;
          end
        end
        OP_NOFIT: status_q <= (kind_q == KIND_ALLOC) ? STAT_NO_SPACE : STAT_UNKNOWN;
        OP_RETRY: retry_q <= 1'b1;
        OP_SCAN_HIT: begin
          k_q   <= idx_q;
          cur_q <= rd;
          if (kind_q == KIND_LOOKUP) begin
            rbytes_q <= rd.bytes[31:0];
          end
        end
        OP_SCAN_NEXT: idx_q <= idx_q + CW'(1);
        OP_FULL: status_q <= STAT_FULL;
        OP_SPLIT, OP_TAKE: begin
          allocs_q <= allocs_q + 32'd1;
          usage_q  <= usage_add;
          if (usage_add > peak_q) begin
            peak_q <= usage_add;
          end
          roff_q   <= cur_q.off;
          rbytes_q <= need_q[31:0];
          if (op_i == OP_SPLIT) begin
            hold_q <= '{busy: 1'b0, bytes: cur_q.bytes - need_q,
                        off: cur_q.off + OFFSET_BITS'(need_q)};
            idx_q  <= k_q + CW'(1);
          end else begin
            nfree_q <= nfree_q - CW'(1);
          end
        end
        OP_SH_WR: begin
          hold_q <= rd;
          idx_q  <= idx_q + CW'(1);
          if (idx_q == cnt_q) begin
            cnt_q <= cnt_q + CW'(1);
          end
        end
        OP_FREE: begin
          nfree_q <= nfree_q + CW'(1);
          frees_q <= frees_q + 32'd1;
          usage_q <= usage_q - cur_q.bytes[31:0];
          chk_q   <= auto_q;
        end
        OP_DIV_START: begin
          num_q  <= (nfree_q <= CW'(1)) ? '0
                    : NW'(nfree_q - CW'(1)) * NW'(FRAG_SCALE);
          rem_q  <= '0;
          quo_q  <= '0;
          dcnt_q <= DCW'(NW);
        end
        OP_DIV_STEP: begin
          num_q  <= num_q << 1;
          dcnt_q <= dcnt_q - DCW'(1);
          if (rem_sh >= {1'b0, cnt_q}) begin
            rem_q <= CW'(rem_sh - {1'b0, cnt_q});
            quo_q <= {quo_q[NW-2:0], 1'b1};
          end else begin
            rem_q <= CW'(rem_sh);
            quo_q <= {quo_q[NW-2:0], 1'b0};
          end
        end
        OP_CHK_CLR: chk_q <= 1'b0;
        OP_OUT: begin
          status_o        <= status_q;
          result_offset_o <= roff_q;
          block_bytes_o   <= rbytes_q;
          bytes_in_use_o  <= usage_q;
          peak_bytes_o    <= peak_q;
          alloc_count_o   <= allocs_q;
          free_count_o    <= frees_q;
          frag_pct_o      <= 7'(quo_q);
        end
        OP_MRG_START: begin
          idx_q  <= CW'(1);
          wptr_q <= '0;
        end
        OP_MRG_LD: cur_q <= rd;
        OP_MRG_CHK: begin
          idx_q <= idx_q + CW'(1);
          if (mrg_ok) begin
            cur_q.bytes <= cur_q.bytes + rd.bytes;
            nfree_q     <= nfree_q - CW'(1);
          end else begin
            cur_q  <= rd;
            wptr_q <= wptr_q + CW'(1);
          end
        end
        OP_MRG_END: begin
          cnt_q <= wptr_q + CW'(1);
          idx_q <= '0;
        end
        OP_CLR_WR: idx_q <= idx_q + CW'(1);
        OP_CLR_END: nfree_q <= cnt_q;
        default: idx_q <= idx_q;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: src/first_fit_block_allocator.sv
// Each item runs scan, shift and merge passes over the table as needed, then a
// bit-serial divider over a clog2(MAX_BLOCKS*100+1)-bit fragmentation numerator.
// One item is processed at a time; the next is taken once the result is registered.
// The table lives in one memory with one write and one registered read port per cycle.
// Reset is asynchronous and active low; afterwards the init state writes the pool's
// single free block, and a pool size write in idle with no item offered does the same.
`default_nettype none
module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS  = DEF_MAX_BLOCKS,
  parameter int unsigned OFFSET_BITS = DEF_OFFSET_BITS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [1:0]             cfg_idx_i,
  input  wire logic [31:0]            cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [2:0]             kind_i,
  input  wire logic [31:0]            req_size_i,
  input  wire logic [4:0]             align_log2_i,
  input  wire logic [OFFSET_BITS-1:0] block_offset_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [2:0]                  status_o,
  output logic [OFFSET_BITS-1:0]      result_offset_o,
  output logic [31:0]                 block_bytes_o,
  output logic [31:0]                 bytes_in_use_o,
  output logic [31:0]                 peak_bytes_o,
  output logic [31:0]                 alloc_count_o,
  output logic [31:0]                 free_count_o,
  output logic [6:0]                  frag_pct_o,
  output logic                        last_o
);

  dp_op_e  op;
  dp_sts_t sts;

  assign last_o = 1'b1;

  ffba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .sts_i      (sts),
    .op_o       (op)
  );

  ffba_dp #(.MAX_BLOCKS(MAX_BLOCKS), .OFFSET_BITS(OFFSET_BITS)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .kind_i          (kind_i),
    .req_size_i      (req_size_i),
    .align_log2_i    (align_log2_i),
    .block_offset_i  (block_offset_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .result_offset_o (result_offset_o),
    .block_bytes_o   (block_bytes_o),
    .bytes_in_use_o  (bytes_in_use_o),
    .peak_bytes_o    (peak_bytes_o),
    .alloc_count_o   (alloc_count_o),
    .free_count_o    (free_count_o),
    .frag_pct_o      (frag_pct_o)
  );

endmodule
`default_nettype wire

// File: src/ffba_checker.sv
`default_nettype none
module ffba_checker
  import ffba_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [2:0] status_o,
  input wire logic [6:0] frag_pct_o
);

  a_busy_after_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block took a second item straight after the first");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o))
    else $error("stalled result changed");

  a_frag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> frag_pct_o <= 7'd100)
    else $error("fragmentation above one hundred percent");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= STAT_FULL)
    else $error("status code out of range");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);
`default_nettype wire
